>>> rtl/nqsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqsc_pkg
// Shared widths and constants for the N-queens solution counter.
// ----------------------------------------------------------------------------
package nqsc_pkg;

  localparam int S_TDATA_W = 8;    // start_req, zero filled to a byte
  localparam int M_TDATA_W = 24;   // solution_count
  localparam int COUNT_W   = 24;
  localparam int CFG_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 24'hFF_FFFF;
  localparam logic [CFG_W-1:0]   BOARD_RESET = 5'd8;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> rtl/n_queens_solution_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_counter_top
// Counts all N-queens placements by depth-first backtracking with one shared
// attack-check and mask-update unit; first-row mirror symmetry for even sizes.
// ----------------------------------------------------------------------------
// Search: each tried square is checked in ST_SEARCH; a backtrack pops the
//   column stack in ST_SEARCH and clears the masks in ST_POPW.
// Throughput: one start transfer at a time; s_axis_tready is low during the
//   search. A finished count waits in the output register while a new start
//   is taken. A start with start_req clear produces no result.
// Reset: board_size returns to 8, the block is idle, no result is pending.
module n_queens_solution_counter_top #(
  parameter int MAX_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nqsc_pkg::CFG_W-1:0]     cfg_wdata,     // board_size
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nqsc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [0] start_req, [7:1] zero
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nqsc_pkg::M_TDATA_W-1:0] m_axis_tdata   // [23:0] solution_count
);

  localparam int SW  = $clog2(MAX_SIZE + 1);
  localparam int AW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DW  = 2 * MAX_SIZE - 1;
  localparam int DIW = (DW > 1) ? $clog2(DW) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_POPW   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]             state;
  logic [nqsc_pkg::CFG_W-1:0] board_size;
  logic [SW-1:0]          n_reg;
  logic [SW-1:0]          first_limit;
  logic                   even;
  logic [SW-1:0]          row;
  logic [SW-1:0]          col;
  logic [MAX_SIZE-1:0]    col_used;
  logic [DW-1:0]          rdiag;
  logic [DW-1:0]          fdiag;
  nqsc_pkg::count_t       count;
  logic [SW-1:0]          stack_mem [MAX_SIZE];
  logic [SW-1:0]          rd_data;

  logic                   s_xfer;
  logic [SW-1:0]          n_start;
  logic [SW-1:0]          limit;
  logic [SW-1:0]          csel;
  logic [SW-1:0]          row_dec;
  logic [SW:0]            rsum;
  logic [SW:0]            fsum;
  logic [AW-1:0]          cidx;
  logic [DIW-1:0]         ridx;
  logic [DIW-1:0]         fidx;
  logic [MAX_SIZE-1:0]    cbit;
  logic [DW-1:0]          rbit;
  logic [DW-1:0]          fbit;
  logic                   free_spot;
  logic                   last_row;
  logic                   over;
  logic [nqsc_pkg::COUNT_W:0] sum;
  nqsc_pkg::count_t       count_sat;
  logic                   mem_we;
  logic                   mem_re;
  logic                   out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // shared check/update unit
  always_comb begin
    n_start = (int'(board_size) > MAX_SIZE) ? SW'(MAX_SIZE) : SW'(board_size);
    limit   = (row == '0) ? first_limit : n_reg;
    over    = (col >= limit);
    csel    = (state == ST_POPW) ? rd_data : col;
    row_dec = row - SW'(1);
    rsum    = {1'b0, row} + {1'b0, csel};
    fsum    = {1'b0, row} + {1'b0, n_reg} - (SW+1)'(1) - {1'b0, csel};
    cidx    = csel[AW-1:0];
    ridx    = rsum[DIW-1:0];
    fidx    = fsum[DIW-1:0];
    cbit    = MAX_SIZE'(1) << cidx;
    rbit    = DW'(1) << ridx;
    fbit    = DW'(1) << fidx;
    free_spot = !col_used[cidx] && !rdiag[ridx] && !fdiag[fidx];
    last_row  = (({1'b0, row} + (SW+1)'(1)) == {1'b0, n_reg});
    sum       = {1'b0, count} + (even ? (nqsc_pkg::COUNT_W+1)'(2)
                                      : (nqsc_pkg::COUNT_W+1)'(1));
    count_sat = (sum > {1'b0, nqsc_pkg::COUNT_MAX}) ? nqsc_pkg::COUNT_MAX
                                                    : sum[nqsc_pkg::COUNT_W-1:0];
    mem_we  = (state == ST_SEARCH) && !over && free_spot && !last_row;
    mem_re  = (state == ST_SEARCH) && over && (row != '0);
  end

  // column stack
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[row[AW-1:0]] <= col;
    end
    if (mem_re) begin
      rd_data <= stack_mem[row_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      board_size    <= nqsc_pkg::BOARD_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        board_size <= cfg_wdata;
      end
      if (m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_xfer && s_axis_tdata[0]) begin
            n_reg       <= n_start;
            even        <= !n_start[0];
            first_limit <= n_start[0] ? n_start : (n_start >> 1);
            row         <= '0;
            col         <= '0;
            col_used    <= '0;
            rdiag       <= '0;
            fdiag       <= '0;
            count       <= '0;
            state       <= (n_start == '0) ? ST_DONE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (over) begin
            if (row == '0) begin
              state <= ST_DONE;
            end else begin
              row   <= row_dec;
              state <= ST_POPW;
            end
          end else if (!free_spot) begin
            col <= col + SW'(1);
          end else if (last_row) begin
            count <= count_sat;
            col   <= col + SW'(1);
          end else begin
            col_used <= col_used | cbit;
            rdiag    <= rdiag | rbit;
            fdiag    <= fdiag | fbit;
            row      <= row + SW'(1);
            col      <= '0;
          end
        end
        ST_POPW: begin
          col_used <= col_used & ~cbit;
          rdiag    <= rdiag & ~rbit;
          fdiag    <= fdiag & ~fbit;
          col      <= rd_data + SW'(1);
          state    <= ST_SEARCH;
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tdata  <= count;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/nqsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqsc_checker
// Port-level checks on the N-queens counter handshakes, bound to the top.
// ----------------------------------------------------------------------------
module nqsc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [nqsc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [nqsc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // a start transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
    else $error("ready still high after a start transfer");

  // an idle transfer leaves the block ready
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tdata[0] |=> s_axis_tready)
    else $error("ready dropped after an idle transfer");

  // a new result only appears at the end of a search
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a search");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind n_queens_solution_counter_top nqsc_checker u_nqsc_checker (.*);
